// ===== rtl/mbps_pkg.sv =====
package mbps_pkg;

	localparam int MBPS_MAX_PATTERN = 64;

	// signature byte that matches any region byte
	localparam logic [7:0] MBPS_WILDCARD = 8'h00;

	typedef enum logic [1:0] {
		REQ_LOAD    = 2'd0,
		REQ_SCAN    = 2'd1,
		REQ_RESTART = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_OFFSET_MODE    = 2'd1,
		REG_FIXED_OFFSET   = 2'd2,
		REG_REGION_START   = 2'd3
	} reg_index_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic       shift;
		logic       rot_up;
		logic       rot_dn;
		logic [7:0] data;
	} cell_ctrl_t;

	typedef struct packed {
		logic hit;
		logic wild;
	} cell_stat_t;

endpackage

// ===== rtl/mbps_cell.sv =====
module mbps_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mbps_pkg::cell_ctrl_t   ctrl,
	input  logic                   active,
	input  logic                   load_en,
	input  logic [7:0]             win_prev,
	input  logic [7:0]             pat_lo,
	input  logic [7:0]             pat_hi,
	output logic [7:0]             win,
	output logic [7:0]             pat,
	output mbps_pkg::cell_stat_t   stat
);
	import mbps_pkg::*;

	logic [7:0] win_q;
	logic [7:0] pat_q;

	// window byte, moves one cell up per scanned byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			win_q <= win_prev;
		end
	end

	// signature byte, rotates around the ring on a length change
	always_ff @(posedge clk) begin
		if (load_en) begin
			pat_q <= ctrl.data;
		end else if (ctrl.rot_up) begin
			pat_q <= pat_lo;
		end else if (ctrl.rot_dn) begin
			pat_q <= pat_hi;
		end
	end

	// compare against the byte that lands here on this beat
	assign stat.hit  = !active || (pat_q == MBPS_WILDCARD) || (pat_q == win_prev);
	assign stat.wild = active && (pat_q == MBPS_WILDCARD);
	assign win       = win_q;
	assign pat       = pat_q;

endmodule

// ===== rtl/mbps_result.sv =====
module mbps_result #(
	parameter int LW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          push_found,
	input  logic [31:0]   push_pos,
	input  logic [LW-1:0] push_len,
	input  logic [15:0]   push_off,
	input  logic [31:0]   region_start,
	input  logic          out_stall,
	output logic          ready,
	output logic          out_valid,
	output logic          found,
	output logic [31:0]   match_address
);

	logic          valid_s1;
	logic          found_s1;
	logic [31:0]   pos_s1;
	logic [LW-1:0] len_s1;
	logic [15:0]   off_s1;
	logic          valid_q;
	logic          found_q;
	logic [31:0]   addr_q;
	logic          out_ready;
	logic          move;
	logic [31:0]   addr_d;

	assign out_ready = !valid_q || !out_stall;
	assign move      = valid_s1 && out_ready;
	assign ready     = !valid_s1 || out_ready;

	// start + (position - length) + offset, wraps mod 2^32
	assign addr_d = found_s1 ? (region_start + (pos_s1 - 32'(len_s1)) + 32'(off_s1)) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (push) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			found_s1 <= push_found;
			pos_s1   <= push_pos;
			len_s1   <= push_len;
			off_s1   <= push_off;
		end
		if (move) begin
			found_q <= found_s1;
			addr_q  <= addr_d;
		end
	end

	assign out_valid     = valid_q;
	assign found         = found_q;
	assign match_address = addr_q;

endmodule

// ===== rtl/masked_byte_pattern_scanner_unit.sv =====
// channel   direction  handshake            payload
// in        to block   in_valid / in_stall  req_type, pattern_index, data_byte, last
// out       from block out_valid / out_stall found, match_address
// cfg       to block   cfg_we               cfg_index, cfg_wdata
//
// one input beat per cycle while in_stall is low; a result passes both result stages to out
// the row of cells compares the whole window in the beat's cycle, so scan bytes
// stream at one per cycle while in_stall is low, with no dependence between them
// a pattern_length write rotates the signature ring one cell per cycle until it is
// aligned to the new length, with in_stall high meanwhile
// reset clears control, window and position; signature bytes are undefined until loaded
// in_stall also rises when a result waits in both result stages and out_stall is high
module masked_byte_pattern_scanner_unit #(
	parameter int MAX_PATTERN = mbps_pkg::MBPS_MAX_PATTERN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [5:0]  pattern_index,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] match_address,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import mbps_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// configuration
	logic [LW-1:0] len_q;      // effective signature length
	logic [LW-1:0] al_q;       // length the ring is currently aligned to
	logic          mode_q;
	logic [15:0]   fixed_q;
	logic [31:0]   start_q;

	// scan state
	logic [31:0]   pos_q;
	logic          done_q;

	logic [6:0]    cfg_len;
	logic [LW-1:0] eff_len;
	logic          busy;
	logic          accept;
	logic          res_ready;
	req_t          req;
	logic          scan_acc;
	logic          load_acc;
	logic          idx_ok;
	int            slot_i;
	logic [IW-1:0] load_slot;
	logic [31:0]   pos_new;
	logic          all_hit;
	logic          hit;
	logic          push;
	logic          any_wild;
	logic [IW-1:0] wild_j;
	logic [15:0]   off_wild;
	logic [15:0]   off_sel;

	cell_ctrl_t                  ctrl;
	cell_stat_t                  stat   [MAX_PATTERN];
	logic [7:0]                  win    [MAX_PATTERN];
	logic [7:0]                  pat    [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]      hits;
	logic [MAX_PATTERN-1:0]      wilds;

	// ---------------------------------------------------------------
	// configuration writes
	// ---------------------------------------------------------------
	assign cfg_len = cfg_wdata[6:0];

	// length zero acts as one, above the store saturates
	always_comb begin
		if (cfg_len == 7'd0) begin
			eff_len = LW'(1);
		end else if (32'(cfg_len) > 32'(MAX_PATTERN)) begin
			eff_len = LW'(MAX_PATTERN);
		end else begin
			eff_len = LW'(cfg_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LW'(1);
			mode_q  <= 1'b0;
			fixed_q <= '0;
			start_q <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PATTERN_LENGTH: len_q   <= eff_len;
				REG_OFFSET_MODE:    mode_q  <= cfg_wdata[0];
				REG_FIXED_OFFSET:   fixed_q <= cfg_wdata[15:0];
				REG_REGION_START:   start_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// signature ring alignment
	// cell j holds signature byte (len - 1 - j) mod MAX_PATTERN, so the
	// window byte j beats old lines up with its signature byte in place;
	// a length change walks the ring one step per cycle
	// ---------------------------------------------------------------
	assign busy = (al_q != len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			al_q <= LW'(1);
		end else if (busy) begin
			if (len_q > al_q) begin
				al_q <= al_q + LW'(1);
			end else begin
				al_q <= al_q - LW'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// input handshake and request decode
	// ---------------------------------------------------------------
	assign in_stall = busy || !res_ready;
	assign accept   = in_valid && !in_stall;
	assign req      = req_t'(req_type);
	assign scan_acc = accept && (req == REQ_SCAN) && !done_q;
	assign load_acc = accept && (req == REQ_LOAD);

	// loads beyond the store are dropped
	assign idx_ok = 32'(pattern_index) < 32'(MAX_PATTERN);

	// ring slot of the loaded signature byte
	always_comb begin
		slot_i = int'(len_q) - 1 - int'(pattern_index);
		if (slot_i < 0) begin
			slot_i = slot_i + MAX_PATTERN;
		end
		load_slot = IW'(slot_i);
	end

	assign ctrl.shift  = scan_acc;
	assign ctrl.rot_up = busy && (len_q > al_q);
	assign ctrl.rot_dn = busy && (len_q < al_q);
	assign ctrl.data   = data_byte;

	// ---------------------------------------------------------------
	// row of cells
	// ---------------------------------------------------------------
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [7:0] prev_byte;
		logic       cell_load;
		logic       cell_active;

		if (j == 0) begin : g_head
			assign prev_byte = data_byte;
		end else begin : g_body
			assign prev_byte = win[j-1];
		end

		assign cell_load   = load_acc && idx_ok && (load_slot == IW'(j));
		assign cell_active = 32'(len_q) > 32'(j);

		mbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.active   (cell_active),
			.load_en  (cell_load),
			.win_prev (prev_byte),
			.pat_lo   (pat[(j + MAX_PATTERN - 1) % MAX_PATTERN]),
			.pat_hi   (pat[(j + 1) % MAX_PATTERN]),
			.win      (win[j]),
			.pat      (pat[j]),
			.stat     (stat[j])
		);

		assign hits[j]  = stat[j].hit;
		assign wilds[j] = stat[j].wild;
	end

	// ---------------------------------------------------------------
	// match decision
	// ---------------------------------------------------------------
	assign pos_new = pos_q + 32'd1;
	assign all_hit = &hits;
	// the match must lie wholly inside the region
	assign hit     = all_hit && (pos_new >= 32'(len_q));
	assign push    = scan_acc && (hit || last);

	// first wildcard in signature order sits in the highest active ring slot
	always_comb begin
		any_wild = 1'b0;
		wild_j   = '0;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (wilds[j]) begin
				any_wild = 1'b1;
				wild_j   = IW'(j);
			end
		end
	end

	assign off_wild = any_wild ? (16'(len_q) - 16'(wild_j) - 16'd1) : 16'(len_q);
	assign off_sel  = mode_q ? off_wild : fixed_q;

	// position and matched flag; a miss on the last byte restarts the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			case (req)
				REQ_RESTART: begin
					pos_q  <= '0;
					done_q <= 1'b0;
				end
				REQ_SCAN: begin
					if (!done_q) begin
						if (hit) begin
							pos_q  <= pos_new;
							done_q <= 1'b1;
						end else if (last) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_new;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// result stages: address add, then output register
	// ---------------------------------------------------------------
	mbps_result #(
		.LW (LW)
	) u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_found    (hit),
		.push_pos      (pos_new),
		.push_len      (len_q),
		.push_off      (off_sel),
		.region_start  (start_q),
		.out_stall     (out_stall),
		.ready         (res_ready),
		.out_valid     (out_valid),
		.found         (found),
		.match_address (match_address)
	);

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_address == 32'd0)
		else $error("miss result carries a nonzero address");

	a_rotate_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("beat accepted while the signature ring is rotating");

	a_match_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		scan_acc && hit |=> done_q)
		else $error("match did not set the matched flag");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req == REQ_RESTART) |=> !done_q && (pos_q == 32'd0))
		else $error("restart left scan state behind");

endmodule
